[design/lkv_pkg.sv]
// shared types and constants for the lru key-value cache
package lkv_pkg;

	localparam int unsigned KEY_W       = 32;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CAP_W       = 5;
	localparam int unsigned ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic en;
		logic put;
		logic hit;
	} ctrl_t;

endpackage

[design/lkv_cell.sv]
// one recency slot: holds an entry, compares the key, shifts from its neighbor
module lkv_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkv_pkg::ctrl_t             ctrl,
	input  logic [lkv_pkg::KEY_W-1:0]  lookup_key,
	input  logic                       keep,
	input  lkv_pkg::entry_t            prev_entry,
	input  logic                       tail_in,
	input  logic [lkv_pkg::DATA_W-1:0] sel_in,
	output lkv_pkg::entry_t            entry,
	output logic                       tail_out,
	output logic [lkv_pkg::DATA_W-1:0] sel_out
);
	import lkv_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              match;
	logic              shift;

	assign match    = valid_q && (key_q == lookup_key);
	assign tail_out = match | tail_in;
	assign sel_out  = sel_in | (match ? data_q : '0);

	// take the neighbor's entry on a miss insert, or when at or above the hit slot
	assign shift = ctrl.en && ((ctrl.put && !ctrl.hit) || (ctrl.hit && tail_out));

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (shift ? prev_entry.valid : valid_q) & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= prev_entry.key;
			data_q <= prev_entry.data;
		end
	end

endmodule

[design/lru_key_value_cache.sv]
// top level of the lru key-value cache: slot chain, capacity register, result register
//
// A fully associative key-value store of ENTRIES slots kept as a chain of cells in
// recency order, most recent first. Every beat on the request channel is a get
// (cmd 0) or a put (cmd 1) and yields one beat on the response channel: hit tells
// whether the key was held before, read_value carries the stored value for a get
// that hits and all ones otherwise. All cells compare the key in the same cycle and
// shift toward the tail in that cycle, so a request is taken every clock while the
// response register is free or being drained; the path that sets the clock is the
// key compare followed by the hit ripple across the cell chain. capacity_in_use
// (reset 16, 0 acts as 1, values above ENTRIES act as ENTRIES) limits how many
// entries are held; writing it drops the least recent entries beyond the new limit.
module lru_key_value_cache #(
	parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]         capacity_in_use,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              cmd,
	input  logic signed [lkv_pkg::KEY_W-1:0]  key,
	input  logic signed [lkv_pkg::DATA_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              hit,
	output logic signed [lkv_pkg::DATA_W-1:0] read_value
);
	import lkv_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES) + 1;
	localparam int unsigned CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  cap_next;
	logic [CAP_W-1:0]  cap_eff;
	logic              accept;
	logic              any_hit;
	logic [DATA_W-1:0] hit_data;
	ctrl_t             ctrl;
	entry_t            head;
	logic              rsp_valid_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_value_q;

	entry_t            chain   [ENTRIES+1];
	logic              tail    [ENTRIES+1];
	logic [DATA_W-1:0] sel     [ENTRIES+1];
	logic              keep    [ENTRIES];

	assign cap_next = cfg_we ? capacity_in_use : cap_q;
	assign cap_eff  = (cap_next == '0) ? CAP_W'(1) : cap_next;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign tail[ENTRIES] = 1'b0;
	assign sel[ENTRIES]  = '0;
	assign any_hit       = tail[0];
	assign hit_data      = sel[0];

	assign ctrl.en  = accept;
	assign ctrl.put = (cmd == CMD_PUT);
	assign ctrl.hit = any_hit;

	// new most recent entry
	assign head.valid = 1'b1;
	assign head.key   = key;
	assign head.data  = (cmd == CMD_PUT) ? value : hit_data;
	assign chain[0]   = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign keep[i] = CMP_W'(i) < CMP_W'(cap_eff);

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.lookup_key (key),
			.keep       (keep[i]),
			.prev_entry (chain[i]),
			.tail_in    (tail[i+1]),
			.sel_in     (sel[i+1]),
			.entry      (chain[i+1]),
			.tail_out   (tail[i]),
			.sel_out    (sel[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			cap_q <= cap_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q        <= any_hit;
			read_value_q <= (cmd == CMD_GET && any_hit) ? hit_data : MISS_VALUE;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

[test/testbench.sv]
// self-checking testbench for the lru key-value cache: directed and random gets/puts against a recency-order model
`timescale 1ns / 100ps

module testbench;
	import lkv_pkg::*;

	localparam int unsigned SLOTS = ENTRIES_DEF;

	typedef struct {
		logic              op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] v;
	} request_t;

	typedef struct {
		logic              hit;
		logic [DATA_W-1:0] rdata;
	} lookup_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CAP_W-1:0]         capacity_in_use = CAP_RESET;
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	logic                     cmd = CMD_GET;
	logic signed [KEY_W-1:0]  key = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;

	lru_key_value_cache u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.capacity_in_use (capacity_in_use),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.cmd             (cmd),
		.key             (key),
		.value           (value),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.hit             (hit),
		.read_value      (read_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// cache image, most recent first
	logic [KEY_W-1:0]  held_key   [SLOTS];
	logic [DATA_W-1:0] held_data  [SLOTS];
	logic              held_valid [SLOTS];
	logic [CAP_W-1:0]  cap_reg = CAP_RESET;

	request_t queued_requests [$];
	lookup_t  awaited_lookups [$];

	bit          idling = 1'b1;
	int unsigned send_gap = 0;
	int unsigned hold_off = 0;
	int unsigned errors = 0;
	int unsigned n_gets = 0;
	int unsigned n_puts = 0;
	int unsigned n_hits = 0;
	int unsigned n_settings = 0;
	request_t    next_req;
	lookup_t     want;

	function automatic int unsigned active_slots();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return cap_reg;
	endfunction

	function automatic void drop_beyond_capacity();
		for (int unsigned i = active_slots(); i < SLOTS; i++)
			held_valid[i] = 1'b0;
	endfunction

	function automatic lookup_t cache_access(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		lookup_t           r;
		int                pos;
		logic [KEY_W-1:0]  mk;
		logic [DATA_W-1:0] md;
		pos = -1;
		for (int i = 0; i < SLOTS; i++)
			if (pos < 0 && held_valid[i] && held_key[i] == k)
				pos = i;
		r.hit   = (pos >= 0);
		r.rdata = MISS_VALUE;
		if (pos >= 0) begin
			if (op == CMD_GET)
				r.rdata = held_data[pos];
			else
				held_data[pos] = v;
			mk = held_key[pos];
			md = held_data[pos];
			for (int i = pos; i > 0; i--) begin
				held_key[i]   = held_key[i-1];
				held_data[i]  = held_data[i-1];
				held_valid[i] = held_valid[i-1];
			end
			held_key[0]   = mk;
			held_data[0]  = md;
			held_valid[0] = 1'b1;
		end else if (op == CMD_PUT) begin
			for (int i = SLOTS - 1; i > 0; i--) begin
				held_key[i]   = held_key[i-1];
				held_data[i]  = held_data[i-1];
				held_valid[i] = held_valid[i-1];
			end
			held_key[0]   = k;
			held_data[0]  = v;
			held_valid[0] = 1'b1;
			drop_beyond_capacity();
		end
		return r;
	endfunction

	task automatic add_request(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		request_t r;
		r.op = op;
		r.k  = k;
		r.v  = v;
		queued_requests.push_back(r);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || req_valid || awaited_lookups.size() != 0);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		wait_drained();
		@(posedge clk);
		cfg_we          <= 1'b1;
		capacity_in_use <= c;
		cap_reg = c;
		drop_beyond_capacity();
		n_settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// small key pool per phase so that hits, updates and evictions are common
	task automatic queue_random_phase(int unsigned count);
		logic [KEY_W-1:0] pool [$];
		int unsigned      pool_n;
		int unsigned      sel;
		logic [KEY_W-1:0] k;
		pool_n = active_slots() * 3 / 2 + 2;
		for (int unsigned i = 0; i < pool_n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				sel = $urandom_range(0, 3);
				pool.push_back(sel == 0 ? 32'h0000_0000 : sel == 1 ? 32'h7fff_ffff :
					sel == 2 ? 32'h8000_0000 : 32'hffff_ffff);
			end else begin
				pool.push_back($urandom);
			end
		end
		for (int unsigned i = 0; i < count; i++) begin
			k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
			add_request(($urandom_range(0, 9) < 5) ? CMD_GET : CMD_PUT, k, $urandom);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				awaited_lookups.push_back(cache_access(cmd, key, value));
				if (cmd == CMD_GET)
					n_gets++;
				else
					n_puts++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					next_req = queued_requests.pop_front();
					req_valid <= 1'b1;
					cmd       <= next_req.op;
					key       <= next_req.k;
					value     <= next_req.v;
					if (idling && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 11);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor, one beat per request in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_lookups.size() == 0) begin
					errors++;
					$display("%0t: response with none outstanding: hit %b read_value %h",
						$time, hit, read_value);
				end else begin
					want = awaited_lookups.pop_front();
					if (hit === 1'b1)
						n_hits++;
					if (hit !== want.hit) begin
						errors++;
						$display("%0t: hit expected %b actual %b", $time, want.hit, hit);
					end
					if (read_value !== want.rdata) begin
						errors++;
						$display("%0t: read_value expected %h actual %h",
							$time, want.rdata, read_value);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				rsp_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				hold_off = $urandom_range(1, 11) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [CAP_W-1:0] caps [11];
		caps = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd0, 5'd15, 5'd16};
		caps[8] = CAP_W'($urandom_range(1, 31));
		for (int i = 0; i < SLOTS; i++)
			held_valid[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity, extreme keys and values, hit, update, miss
		add_request(CMD_GET, 32'h0000_0000, 32'h1111_1111);
		add_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
		add_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
		add_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
		add_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
		add_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		add_request(CMD_PUT, 32'hffff_ffff, 32'h0000_1234);
		add_request(CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
		add_request(CMD_GET, 32'h5a5a_5a5a, 32'h0000_0000);

		// zero acts as one and drops the older entries
		write_capacity(5'd0);
		add_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
		add_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		add_request(CMD_PUT, 32'h0000_0000, 32'ha5a5_a5a5);
		add_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);

		// eviction of the least recent entry when full
		write_capacity(5'd2);
		add_request(CMD_PUT, 32'h0000_0001, 32'h0000_0011);
		add_request(CMD_PUT, 32'h0000_0002, 32'h0000_0022);
		add_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
		add_request(CMD_PUT, 32'h0000_0003, 32'h0000_0033);
		add_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
		add_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
		add_request(CMD_PUT, 32'h0000_0003, 32'h0000_0000);
		add_request(CMD_GET, 32'h0000_0003, 32'hffff_ffff);

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			idling = (p != 3 && p != 10);
			queue_random_phase(90);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d gets and %0d puts (%0d hits) over %0d capacity settings",
			n_gets, n_puts, n_hits, n_settings);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d responses outstanding", awaited_lookups.size());
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
test/testbench.sv
